// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define PFLD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define PFLD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: src/pfld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfld_pkg
// Geometry, command codes and shared types of the page framebuffer drawer.
// ----------------------------------------------------------------------------
package pfld_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 128;
  localparam int PAGE_ROWS      = 8;
  localparam int PAGE_SHIFT     = $clog2(PAGE_ROWS);
  localparam int PAGE_COUNT     = DISPLAY_HEIGHT / PAGE_ROWS;
  localparam int STORE_DEPTH    = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);

  localparam int COORD_W = 7;
  localparam int PAGE_W  = 4;
  localparam int MODE_W  = 3;
  localparam int DATA_W  = 8;
  // error term spans roughly -2*dx .. 2*dy
  localparam int D_W     = COORD_W + 3;

  localparam logic [DATA_W-1:0] FILL_ONES  = 8'hff;
  localparam logic [DATA_W-1:0] FILL_ZEROS = 8'h00;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_PIXEL    = 3'd0,
    MODE_CLEAR_PIXEL  = 3'd1,
    MODE_DRAW_LINE    = 3'd2,
    MODE_CLEAR_SCREEN = 3'd3,
    MODE_FILL_SCREEN  = 3'd4,
    MODE_READ_BYTE    = 3'd5,
    // unused codes: no effect, all-zero result
    MODE_SPARE_A      = 3'd6,
    MODE_SPARE_B      = 3'd7
  } mode_e;

  typedef struct packed {
    logic                 reject;
    logic                 vertical;
    logic [COORD_W-1:0]   dx;
    logic [COORD_W-1:0]   dy;
    logic signed [D_W-1:0] d0;
  } line_plan_t;

endpackage

// File: src/pfld_line_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfld_line_decode
// Classifies a line command and computes its Bresenham setup values.
// ----------------------------------------------------------------------------
module pfld_line_decode (
  input  logic [pfld_pkg::COORD_W-1:0] x_start_i,
  input  logic [pfld_pkg::COORD_W-1:0] y_start_i,
  input  logic [pfld_pkg::COORD_W-1:0] x_end_i,
  input  logic [pfld_pkg::COORD_W-1:0] y_end_i,
  output pfld_pkg::line_plan_t         plan_o
);
  import pfld_pkg::*;

  logic [COORD_W-1:0]    dx, dy;
  logic signed [D_W-1:0] two_dy, dx_s;
  logic                  vertical;

  assign vertical = (x_start_i == x_end_i);
  assign dx       = x_end_i - x_start_i;
  assign dy       = y_end_i - y_start_i;
  assign two_dy   = D_W'(dy) << 1;
  assign dx_s     = D_W'(dx);

  always_comb begin
    plan_o.vertical = vertical;
    plan_o.dx       = dx;
    plan_o.dy       = dy;
    plan_o.d0       = two_dy - dx_s;
    if (vertical) begin
      plan_o.reject = (y_start_i > y_end_i);
    end else begin
      // dx/dy only meaningful once both orderings are known good
      plan_o.reject = (x_start_i > x_end_i) || (y_start_i > y_end_i) || (dy > dx);
    end
  end

endmodule

// File: src/page_framebuffer_line_drawer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_line_drawer
// Paged monochrome framebuffer with pixel, screen, read-back and line commands.
// ----------------------------------------------------------------------------
// Set/clear pixel, rejected line, unused mode: result in the cycle after accept, busy stays low.
// Read byte: busy in RDWAIT for the registered RAM read; an out-of-range address acts like an unused mode.
// Line: one pixel per cycle through the RAM read-modify-write pipe; the next command
//   is taken in the result cycle.
// Clear/fill screen: one RAM write per cycle over every entry, then the result.
// Reset: a clearing pass over every entry with busy high; results cannot be stalled.
module page_framebuffer_line_drawer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pfld_pkg::MODE_W-1:0]   mode_i,
  input  logic [pfld_pkg::COORD_W-1:0]  x_start_i,
  input  logic [pfld_pkg::COORD_W-1:0]  y_start_i,
  input  logic [pfld_pkg::COORD_W-1:0]  x_end_i,
  input  logic [pfld_pkg::COORD_W-1:0]  y_end_i,
  input  logic [pfld_pkg::PAGE_W-1:0]   read_page_i,
  input  logic [pfld_pkg::COORD_W-1:0]  read_column_i,
  output logic                          done_o,
  output logic [pfld_pkg::DATA_W-1:0]   read_data_o,
  output logic                          line_unsupported_o
);
  import pfld_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LINE   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;

  function automatic logic on_screen(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return (int'(x) < DISPLAY_WIDTH) && (int'(y >> PAGE_SHIFT) < PAGE_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] page);
    return ADDR_W'(int'(col) + int'(page) * DISPLAY_WIDTH);
  endfunction

  // frame memory
  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata_q;

  // write-back forwarding for a read that met a write to the same entry
  logic              fwd_hit_q;
  logic [DATA_W-1:0] fwd_data_q, rd_eff;

  logic [2:0]            state_q, state_d;
  logic [COORD_W-1:0]    x_q, x_d, y_q, y_d, cnt_q, cnt_d, dx_q, dx_d, dy_q, dy_d;
  logic signed [D_W-1:0] d_q, d_d, two_dx, two_dy;
  logic                  vert_q, vert_d;
  logic [ADDR_W-1:0]     sweep_q, sweep_d;
  logic [DATA_W-1:0]     fill_q, fill_d;

  // modify/write stage
  logic              s1_valid_q, s1_valid_d, s1_set_q, s1_set_d;
  logic [ADDR_W-1:0] s1_addr_q, s1_addr_d;
  logic [DATA_W-1:0] s1_mask_q, s1_mask_d;

  logic              done_q, done_d, flag_q, flag_d;
  logic [DATA_W-1:0] data_q, data_d;

  line_plan_t plan;
  logic       sweeping, sweep_last;

  pfld_line_decode u_line_decode (
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .plan_o    (plan)
  );

  assign rd_eff     = fwd_hit_q ? fwd_data_q : mem_rdata_q;
  assign sweeping   = (state_q == ST_INIT) || (state_q == ST_FILL);
  assign sweep_last = (sweep_q == ADDR_W'(STORE_DEPTH - 1));
  assign two_dx     = D_W'(dx_q) << 1;
  assign two_dy     = D_W'(dy_q) << 1;

  always_comb begin
    mem_we    = sweeping || s1_valid_q;
    mem_waddr = sweeping ? sweep_q : s1_addr_q;
    if (sweeping) begin
      mem_wdata = fill_q;
    end else if (s1_set_q) begin
      mem_wdata = rd_eff | s1_mask_q;
    end else begin
      mem_wdata = rd_eff & ~s1_mask_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    d_d        = d_q;
    cnt_d      = cnt_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    vert_d     = vert_q;
    sweep_d    = sweep_q;
    fill_d     = fill_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    s1_valid_d = 1'b0;
    s1_addr_d  = s1_addr_q;
    s1_mask_d  = s1_mask_q;
    s1_set_d   = s1_set_q;
    done_d     = 1'b0;
    data_d     = '0;
    flag_d     = 1'b0;

    case (state_q)
      ST_INIT: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (mode_e'(mode_i))
            MODE_SET_PIXEL, MODE_CLEAR_PIXEL: begin
              done_d = 1'b1;
              if (on_screen(x_start_i, y_start_i)) begin
                mem_re     = 1'b1;
                mem_raddr  = store_addr(x_start_i, y_start_i >> PAGE_SHIFT);
                s1_valid_d = 1'b1;
                s1_addr_d  = mem_raddr;
                s1_mask_d  = DATA_W'(1) << y_start_i[PAGE_SHIFT-1:0];
                s1_set_d   = (mode_e'(mode_i) == MODE_SET_PIXEL);
              end
            end
            MODE_DRAW_LINE: begin
              if (plan.reject) begin
                done_d = 1'b1;
                flag_d = 1'b1;
              end else begin
                x_d     = x_start_i;
                y_d     = y_start_i;
                d_d     = plan.d0;
                dx_d    = plan.dx;
                dy_d    = plan.dy;
                vert_d  = plan.vertical;
                cnt_d   = plan.vertical ? plan.dy : plan.dx;
                state_d = ST_LINE;
              end
            end
            MODE_CLEAR_SCREEN: begin
              fill_d  = FILL_ZEROS;
              sweep_d = '0;
              state_d = ST_FILL;
            end
            MODE_FILL_SCREEN: begin
              fill_d  = FILL_ONES;
              sweep_d = '0;
              state_d = ST_FILL;
            end
            MODE_READ_BYTE: begin
              if ((int'(read_page_i) < PAGE_COUNT) &&
                  (int'(read_column_i) < DISPLAY_WIDTH)) begin
                mem_re    = 1'b1;
                mem_raddr = store_addr(read_column_i, COORD_W'(read_page_i));
                state_d   = ST_RDWAIT;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_LINE: begin
        // plot first, then step
        if (on_screen(x_q, y_q)) begin
          mem_re     = 1'b1;
          mem_raddr  = store_addr(x_q, y_q >> PAGE_SHIFT);
          s1_valid_d = 1'b1;
          s1_addr_d  = mem_raddr;
          s1_mask_d  = DATA_W'(1) << y_q[PAGE_SHIFT-1:0];
          s1_set_d   = 1'b1;
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (vert_q) begin
            y_d = y_q + 1'b1;
          end else begin
            x_d = x_q + 1'b1;
            if (d_q > 0) begin
              y_d = y_q + 1'b1;
              d_d = d_q + two_dy - two_dx;
            end else begin
              d_d = d_q + two_dy;
            end
          end
        end
      end
      ST_FILL: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        done_d  = 1'b1;
        data_d  = rd_eff;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      sweep_q    <= '0;
      fill_q     <= FILL_ZEROS;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      done_q     <= 1'b0;
      data_q     <= '0;
      flag_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
      fwd_hit_q  <= mem_re && mem_we && (mem_waddr == mem_raddr);
      done_q     <= done_d;
      data_q     <= data_d;
      flag_q     <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    d_q        <= d_d;
    cnt_q      <= cnt_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    vert_q     <= vert_d;
    s1_addr_q  <= s1_addr_d;
    s1_mask_q  <= s1_mask_d;
    s1_set_q   <= s1_set_d;
    fwd_data_q <= mem_wdata;
  end

  assign busy               = (state_q != ST_IDLE);
  assign done_o             = done_q;
  assign read_data_o        = data_q;
  assign line_unsupported_o = flag_q;

endmodule

// File: src/pfld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfld_checker
// Port-level timing checks of the page framebuffer drawer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfld_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [pfld_pkg::MODE_W-1:0]   mode_i,
  input logic                          done_o,
  input logic [pfld_pkg::DATA_W-1:0]   read_data_o,
  input logic                          line_unsupported_o
);
  import pfld_pkg::*;

  logic accept, quick_cmd, read_cmd, clean_done;

  assign accept     = start && !busy;
  assign quick_cmd  = (mode_i == MODE_SET_PIXEL) || (mode_i == MODE_CLEAR_PIXEL) ||
                      (mode_i == MODE_SPARE_A) || (mode_i == MODE_SPARE_B);
  assign read_cmd   = (mode_i == MODE_READ_BYTE);
  assign clean_done = done_o && (read_data_o == '0);

  // a result always leaves the block ready for the next transaction
  `PFLD_ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy,
                     "result strobe while busy")

  `PFLD_ASSERT(a_flag_only_on_result, clk_i, rst_ni, line_unsupported_o |-> clean_done,
               "line flag outside a clean result")

  `PFLD_ASSERT(a_quick_result, clk_i, rst_ni,
               (accept && quick_cmd) |=> (clean_done && !line_unsupported_o),
               "pixel or unused command result missing")

  `PFLD_ASSERT(a_read_wait, clk_i, rst_ni,
               (accept && read_cmd) |=> ((busy && !done_o) || clean_done),
               "read byte timing broken")

endmodule

bind page_framebuffer_line_drawer pfld_checker u_pfld_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .mode_i             (mode_i),
  .done_o             (done_o),
  .read_data_o        (read_data_o),
  .line_unsupported_o (line_unsupported_o)
);

// File: verif/tb_page_framebuffer_line_drawer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_line_drawer
// Drives pixel, line, screen and read-back commands into the paged framebuffer
// and checks every result against a software copy of the frame store.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_line_drawer;
  import pfld_pkg::*;

  localparam int RANDOM_ITEMS  = 1130;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int SETTLE_CYCLES = 2100;
  localparam int MAX_GAP       = 20;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              unsupported;
  } drawer_result_t;

  class frame_scoreboard;
    logic [DATA_W-1:0] frame[STORE_DEPTH];
    drawer_result_t    expected_results[$];
    int                mismatches;

    function new();
      foreach (frame[i]) frame[i] = FILL_ZEROS;
      mismatches = 0;
    endfunction

    function void plot(int x, int y, bit on);
      int addr;
      if (x >= DISPLAY_WIDTH || (y >> PAGE_SHIFT) >= PAGE_COUNT) return;
      addr = x + (y >> PAGE_SHIFT) * DISPLAY_WIDTH;
      frame[addr][y % PAGE_ROWS] = on;
    endfunction

    // returns 1 when the line is rejected
    function bit draw_line(int x1, int y1, int x2, int y2);
      int err;
      int y;
      if (x1 == x2) begin
        if (y1 > y2) return 1'b1;
        for (int r = y1; r <= y2; r++) plot(x1, r, 1'b1);
        return 1'b0;
      end
      if (x1 > x2 || y1 > y2 || (y2 - y1) > (x2 - x1)) return 1'b1;
      err = 2 * (y2 - y1) - (x2 - x1);
      y = y1;
      for (int x = x1; x <= x2; x++) begin
        plot(x, y, 1'b1);
        if (err > 0) begin
          y++;
          err -= 2 * (x2 - x1);
        end
        err += 2 * (y2 - y1);
      end
      return 1'b0;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] xs,
                               logic [COORD_W-1:0] ys, logic [COORD_W-1:0] xe,
                               logic [COORD_W-1:0] ye, logic [PAGE_W-1:0] rp,
                               logic [COORD_W-1:0] rc);
      drawer_result_t res;
      res.data = FILL_ZEROS;
      res.unsupported = 1'b0;
      case (mode)
        MODE_SET_PIXEL:    plot(int'(xs), int'(ys), 1'b1);
        MODE_CLEAR_PIXEL:  plot(int'(xs), int'(ys), 1'b0);
        MODE_DRAW_LINE:    res.unsupported = draw_line(int'(xs), int'(ys), int'(xe), int'(ye));
        MODE_CLEAR_SCREEN: foreach (frame[i]) frame[i] = FILL_ZEROS;
        MODE_FILL_SCREEN:  foreach (frame[i]) frame[i] = FILL_ONES;
        MODE_READ_BYTE: begin
          if (int'(rp) < PAGE_COUNT && int'(rc) < DISPLAY_WIDTH)
            res.data = frame[int'(rc) + int'(rp) * DISPLAY_WIDTH];
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic unsupported);
      drawer_result_t exp_res;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result data=%02h unsupported=%b", data, unsupported);
        return;
      end
      exp_res = expected_results.pop_front();
      if (data !== exp_res.data || unsupported !== exp_res.unsupported) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected data=%02h unsupported=%b, got data=%02h unsupported=%b",
                   exp_res.data, exp_res.unsupported, data, unsupported);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode_i;
  logic [COORD_W-1:0]  x_start_i;
  logic [COORD_W-1:0]  y_start_i;
  logic [COORD_W-1:0]  x_end_i;
  logic [COORD_W-1:0]  y_end_i;
  logic [PAGE_W-1:0]   read_page_i;
  logic [COORD_W-1:0]  read_column_i;
  logic                done_o;
  logic [DATA_W-1:0]   read_data_o;
  logic                line_unsupported_o;

  frame_scoreboard sb = new();
  bit              idle_enabled;
  int              focus_x;
  int              focus_y;

  page_framebuffer_line_drawer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .x_start_i          (x_start_i),
    .y_start_i          (y_start_i),
    .x_end_i            (x_end_i),
    .y_end_i            (y_end_i),
    .read_page_i        (read_page_i),
    .read_column_i      (read_column_i),
    .done_o             (done_o),
    .read_data_o        (read_data_o),
    .line_unsupported_o (line_unsupported_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results are checked before the same edge's transaction is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(read_data_o, line_unsupported_o);
      if (start && !busy)
        sb.note_command(mode_i, x_start_i, y_start_i, x_end_i, y_end_i,
                        read_page_i, read_column_i);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("page_framebuffer_line_drawer: mismatch");
    $finish;
  end

  task automatic issue_command(input logic [MODE_W-1:0] mode,
                               input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                               input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                               input logic [PAGE_W-1:0] rp, input logic [COORD_W-1:0] rc);
    int gap;
    gap = 0;
    if (idle_enabled)
      while ($urandom_range(99) < 35 && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= mode;
    x_start_i     <= xs;
    y_start_i     <= ys;
    x_end_i       <= xe;
    y_end_i       <= ye;
    read_page_i   <= rp;
    read_column_i <= rc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic random_command();
    int unsigned pick;
    int unsigned kind;
    int          dx;
    int          dy;
    logic [MODE_W-1:0]  m;
    logic [COORD_W-1:0] xs, ys, xe, ye, rc;
    logic [PAGE_W-1:0]  rp;
    pick = $urandom_range(99);
    xs = COORD_W'($urandom); ys = COORD_W'($urandom);
    xe = COORD_W'($urandom); ye = COORD_W'($urandom);
    rp = PAGE_W'($urandom); rc = COORD_W'($urandom);
    if (pick < 28) begin
      m = (pick < 18) ? MODE_SET_PIXEL : MODE_CLEAR_PIXEL;
      if ($urandom_range(99) < 60) begin
        xs = COORD_W'(focus_x + $urandom_range(0, 7));
        ys = COORD_W'(focus_y + $urandom_range(0, 7));
      end
      focus_x = int'(xs);
      focus_y = int'(ys);
    end else if (pick < 58) begin
      m = MODE_DRAW_LINE;
      kind = $urandom_range(9);
      if (kind < 6) begin
        // first octant
        if (xs == 7'd127) xs = COORD_W'($urandom_range(0, 126));
        dx = (kind < 4) ? $urandom_range(1, (127 - xs < 12) ? 127 - xs : 12)
                        : $urandom_range(1, 127 - xs);
        dy = $urandom_range(0, dx);
        xe = COORD_W'(int'(xs) + dx);
        ys = COORD_W'($urandom_range(0, 127 - dy));
        ye = COORD_W'(int'(ys) + dy);
      end else if (kind < 8) begin
        xe = xs;
        ye = COORD_W'(int'(ys) +
                      $urandom_range(0, (kind == 6 && ys < 116) ? 11 : 127 - ys));
      end
      focus_x = int'(xs);
      focus_y = int'(ys);
    end else if (pick < 94) begin
      m = MODE_READ_BYTE;
      if ($urandom_range(99) < 75) begin
        rc = COORD_W'(focus_x + $urandom_range(0, 7));
        rp = PAGE_W'(((focus_y + $urandom_range(0, 7)) % DISPLAY_HEIGHT) >> PAGE_SHIFT);
      end
    end else if (pick < 96) begin
      m = MODE_CLEAR_SCREEN;
    end else if (pick < 98) begin
      m = MODE_FILL_SCREEN;
    end else begin
      m = (pick == 98) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    issue_command(m, xs, ys, xe, ye, rp, rc);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    mode_i        <= MODE_SET_PIXEL;
    x_start_i     <= '0;
    y_start_i     <= '0;
    x_end_i       <= '0;
    y_end_i       <= '0;
    read_page_i   <= '0;
    read_column_i <= '0;
    idle_enabled  = 1'b1;
    focus_x       = 0;
    focus_y       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, every mode, rejected line shapes, single point, spare modes
    issue_command(MODE_SET_PIXEL,    7'd0,   7'd0,   7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_SET_PIXEL,    7'd127, 7'd127, 7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd15, 7'd127);
    issue_command(MODE_CLEAR_PIXEL,  7'd127, 7'd127, 7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd15, 7'd127);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd0,   7'd0,   7'd127, 7'd127, 4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd0,   7'd10,  7'd127, 7'd73,  4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd1,  7'd2);
    issue_command(MODE_DRAW_LINE,    7'd0,   7'd64,  7'd127, 7'd64,  4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd5,   7'd0,   7'd5,   7'd127, 4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd9,  7'd5);
    issue_command(MODE_DRAW_LINE,    7'd9,   7'd9,   7'd9,   7'd9,   4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd1,  7'd9);
    issue_command(MODE_DRAW_LINE,    7'd20,  7'd5,   7'd10,  7'd5,   4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd10,  7'd8,   7'd20,  7'd5,   4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd10,  7'd0,   7'd12,  7'd9,   4'd0,  7'd0);
    issue_command(MODE_DRAW_LINE,    7'd30,  7'd90,  7'd30,  7'd40,  4'd0,  7'd0);
    issue_command(MODE_FILL_SCREEN,  7'd0,   7'd0,   7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_CLEAR_PIXEL,  7'd64,  7'd66,  7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd8,  7'd64);
    issue_command(MODE_CLEAR_SCREEN, 7'd0,   7'd0,   7'd0,   7'd0,   4'd0,  7'd0);
    issue_command(MODE_READ_BYTE,    7'd0,   7'd0,   7'd0,   7'd0,   4'd8,  7'd65);
    issue_command(MODE_SPARE_A,      7'd127, 7'd127, 7'd127, 7'd127, 4'd15, 7'd127);
    issue_command(MODE_SPARE_B,      7'd1,   7'd2,   7'd3,   7'd4,   4'd5,  7'd6);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_enabled = !(i >= 300 && i < 550);
      if (i % 150 == 149) wait_for_drain();
      random_command();
    end

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("page_framebuffer_line_drawer: match");
    else
      $display("page_framebuffer_line_drawer: mismatch");
    $finish;
  end

endmodule

// File: page_framebuffer_line_drawer.f
+incdir+src
src/pfld_pkg.sv
src/pfld_line_decode.sv
src/page_framebuffer_line_drawer.sv
src/pfld_checker.sv
verif/tb_page_framebuffer_line_drawer.sv
